// File: rtl/core/laser_range_data_decoder_assert.svh
// Assertion macros shared by the decoder RTL.
`ifndef LASER_RANGE_DATA_DECODER_ASSERT_SVH
`define LASER_RANGE_DATA_DECODER_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define LRDD_ASSERT_ALWAYS(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("%m: invariant violated");

// The consequent must hold in the cycle after the antecedent.
`define LRDD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define LRDD_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: implication failed");

`endif

// File: rtl/core/lrdd_pkg.sv
`timescale 1ns / 1ps

package lrdd_pkg;

  localparam int unsigned CHARS_PER_VALUE = 3;
  localparam int unsigned MAX_COUNT       = 4095;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SIX_W      = 6;
  localparam int unsigned VALUE_W    = 18;
  localparam int unsigned CLASS_W    = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned MODEL_W    = 2;
  localparam int unsigned EXPECT_W   = 12;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned CHAR_IDX_W = 3;
  localparam int unsigned TOTAL_W    = CHAR_IDX_W + 1;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned TDATA_OUT_W = 40;

  localparam logic [BYTE_W-1:0] LF_CHAR    = 8'h0A;
  localparam logic [BYTE_W-1:0] DIGIT_BASE = 8'h30;

  localparam logic [VALUE_W-1:0] LONG_TOO_FAR = VALUE_W'(4);
  localparam logic [VALUE_W-1:0] MIN_RANGE_RESET = VALUE_W'(20);

  localparam logic [CHAR_IDX_W-1:0] CPV_IDX = CHAR_IDX_W'(CHARS_PER_VALUE);
  localparam logic [TOTAL_W-1:0] CPV_IDX_TWICE = TOTAL_W'(2 * CHARS_PER_VALUE);
  localparam logic [COUNT_W-1:0] MAX_COUNT_C = COUNT_W'(MAX_COUNT);

  localparam logic [CFG_IDX_W-1:0] REG_REMISSION_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_MODEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_CNT = 2'd3;

  localparam logic [MODEL_W-1:0] MODEL_SHORT = 2'd0;
  localparam logic [MODEL_W-1:0] MODEL_LONG  = 2'd1;

  localparam logic KIND_VALUE = 1'b0;
  localparam logic KIND_END   = 1'b1;

  localparam logic [CLASS_W-1:0] CLASS_VALID     = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_TOO_FAR   = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_MEAS_ERR  = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_OTHER_ERR = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_FEW   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TOO_MANY  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_PARTIAL   = 2'd3;

  function automatic logic [CLASS_W-1:0] classify_range(
    input logic [VALUE_W-1:0] r,
    input logic [VALUE_W-1:0] min_r,
    input logic [MODEL_W-1:0] model
  );
    logic [CLASS_W-1:0] cls;
    cls = CLASS_VALID;
    if (r < min_r) begin
      if (model == MODEL_SHORT) begin
        cls = (r == '0) ? CLASS_TOO_FAR : CLASS_MEAS_ERR;
      end else if (model == MODEL_LONG) begin
        if (r == LONG_TOO_FAR) begin
          cls = CLASS_TOO_FAR;
        end else if (r > LONG_TOO_FAR) begin
          cls = CLASS_OTHER_ERR;
        end
      end
    end
    return cls;
  endfunction

endpackage

// File: rtl/core/laser_range_data_decoder.sv
`timescale 1ns / 1ps

// Decodes the data section of a scanner reply, one ASCII byte per transfer. Each byte is held
// until the next one arrives: a byte followed by a line feed is a line checksum and is dropped,
// and every other byte but a line feed contributes six bits. Three characters give an 18-bit
// range, followed by three remission characters when remission is enabled. A value result
// leaves for every completed value, and two line feeds in a row produce an end-of-block result
// with tlast high and a status: partial value, or value count against expected count. One byte
// is taken per clock cycle unless stalled; each byte passes through one stage of logic into the
// output register, so a result appears in the cycle after the transfer of the byte that follows
// its last character. Configuration must be written while no transfer is in progress.
module laser_range_data_decoder
  import lrdd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // Fields from bit 0: rx_byte.
  input  logic [BYTE_W-1:0]      s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // Fields from bit 0: range_mm, remission_level, range_class, block_status.
  output logic [TDATA_OUT_W-1:0] m_axis_tdata_o,
  // Fields from bit 0: item_kind.
  output logic                   m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  logic                  rem_en_q;
  logic [MODEL_W-1:0]    model_q;
  logic [VALUE_W-1:0]    min_range_q;
  logic [EXPECT_W-1:0]   expected_q;

  logic [BYTE_W-1:0]     held_byte_q, held_byte_d;
  logic                  held_valid_q, held_valid_d;
  logic [CHAR_IDX_W-1:0] char_idx_q, char_idx_d;
  logic [VALUE_W-1:0]    range_q, range_d;
  logic [VALUE_W-1:0]    rem_q, rem_d;
  logic [COUNT_W-1:0]    count_q, count_d;

  logic                  out_valid_q, out_valid_d;
  logic                  out_kind_q, out_kind_d;
  logic [VALUE_W-1:0]    out_range_q, out_range_d;
  logic [VALUE_W-1:0]    out_rem_q, out_rem_d;
  logic [CLASS_W-1:0]    out_class_q, out_class_d;
  logic [STATUS_W-1:0]   out_status_q, out_status_d;

  logic                  in_xfer;
  logic                  produce;
  logic                  end_blk;
  logic [SIX_W-1:0]      six;
  logic [VALUE_W-1:0]    range_new, rem_new;
  logic [CHAR_IDX_W-1:0] idx_inc;
  logic [TOTAL_W-1:0]    total;
  logic [COUNT_W-1:0]    expected_ext;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_en_q    <= 1'b0;
      model_q     <= MODEL_SHORT;
      min_range_q <= MIN_RANGE_RESET;
      expected_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_REMISSION_EN: rem_en_q    <= cfg_data_i[0];
        REG_DEVICE_MODEL: model_q     <= cfg_data_i[MODEL_W-1:0];
        REG_MIN_RANGE:    min_range_q <= cfg_data_i[VALUE_W-1:0];
        REG_EXPECTED_CNT: expected_q  <= cfg_data_i[EXPECT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign six          = SIX_W'(held_byte_q - DIGIT_BASE);
  assign idx_inc      = char_idx_q + CHAR_IDX_W'(1);
  assign total        = rem_en_q ? CPV_IDX_TWICE : {1'b0, CPV_IDX};
  assign expected_ext = COUNT_W'(expected_q);
  assign range_new    = (char_idx_q < CPV_IDX) ? {range_q[VALUE_W-SIX_W-1:0], six} : range_q;
  assign rem_new      = (char_idx_q < CPV_IDX) ? rem_q : {rem_q[VALUE_W-SIX_W-1:0], six};

  always_comb begin
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    char_idx_d   = char_idx_q;
    range_d      = range_q;
    rem_d        = rem_q;
    count_d      = count_q;
    produce      = 1'b0;
    end_blk      = 1'b0;
    out_kind_d   = out_kind_q;
    out_range_d  = out_range_q;
    out_rem_d    = out_rem_q;
    out_class_d  = out_class_q;
    out_status_d = out_status_q;

    if (in_xfer) begin
      held_byte_d  = s_axis_tdata_i;
      held_valid_d = 1'b1;
      if (held_valid_q) begin
        if (s_axis_tdata_i == LF_CHAR) begin
          if (held_byte_q == LF_CHAR) begin
            end_blk      = 1'b1;
            produce      = 1'b1;
            out_kind_d   = KIND_END;
            out_range_d  = '0;
            out_rem_d    = '0;
            out_class_d  = CLASS_VALID;
            if (char_idx_q != '0) begin
              out_status_d = STATUS_PARTIAL;
            end else if (count_q < expected_ext) begin
              out_status_d = STATUS_TOO_FEW;
            end else if (count_q > expected_ext) begin
              out_status_d = STATUS_TOO_MANY;
            end else begin
              out_status_d = STATUS_OK;
            end
            char_idx_d   = '0;
            range_d      = '0;
            rem_d        = '0;
            count_d      = '0;
            held_byte_d  = '0;
            held_valid_d = 1'b0;
          end
        end else if (held_byte_q != LF_CHAR) begin
          if ({1'b0, idx_inc} >= total) begin
            produce      = 1'b1;
            out_kind_d   = KIND_VALUE;
            out_range_d  = range_new;
            out_rem_d    = rem_en_q ? rem_new : '0;
            out_class_d  = classify_range(range_new, min_range_q, model_q);
            out_status_d = STATUS_OK;
            if (count_q < MAX_COUNT_C) begin
              count_d = count_q + COUNT_W'(1);
            end
            char_idx_d = '0;
            range_d    = '0;
            rem_d      = '0;
          end else begin
            char_idx_d = idx_inc;
            range_d    = range_new;
            rem_d      = rem_new;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (produce) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_byte_q  <= '0;
      held_valid_q <= 1'b0;
      char_idx_q   <= '0;
      range_q      <= '0;
      rem_q        <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
      char_idx_q   <= char_idx_d;
      range_q      <= range_d;
      rem_q        <= rem_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q   <= out_kind_d;
    out_range_q  <= out_range_d;
    out_rem_q    <= out_rem_d;
    out_class_q  <= out_class_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_status_q, out_class_q, out_rem_q, out_range_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_kind_q;

`include "laser_range_data_decoder_assert.svh"

  `LRDD_ASSERT_ALWAYS(a_char_idx_bound, {1'b0, char_idx_q} < CPV_IDX_TWICE)
  `LRDD_ASSERT_ALWAYS(a_count_bound, count_q <= MAX_COUNT_C)
  `LRDD_ASSERT_NEXT(a_end_clears, end_blk, !held_valid_q && (count_q == '0) && (char_idx_q == '0))
  `LRDD_ASSERT_IMPLY(a_value_status, m_axis_tvalid_o && (m_axis_tuser_o == KIND_VALUE), out_status_q == STATUS_OK)

endmodule

// File: verif/tb_laser_range_data_decoder.sv
`timescale 1ns / 1ps

module tb_laser_range_data_decoder;
  import lrdd_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_BYTES = 1150;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  typedef struct packed {
    logic                kind;
    logic [VALUE_W-1:0]  range_v;
    logic [VALUE_W-1:0]  rem_v;
    logic [CLASS_W-1:0]  cls;
    logic [STATUS_W-1:0] status;
    logic                last;
  } scan_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_valid = 1'b0;
  logic [BYTE_W-1:0]      s_data = '0;
  logic                   m_ready = 1'b0;
  wire                    cfg_ready;
  wire                    s_ready;
  wire                    m_valid;
  wire [TDATA_OUT_W-1:0]  m_data;
  wire                    m_user;
  wire                    m_last;

  // Decoder state and register copy kept by the testbench.
  logic                   rem_on = 1'b0;
  logic [MODEL_W-1:0]     model_sel = MODEL_SHORT;
  logic [VALUE_W-1:0]     min_rng = MIN_RANGE_RESET;
  logic [EXPECT_W-1:0]    count_goal = '0;
  logic [BYTE_W-1:0]      held_char = '0;
  logic                   held_ok = 1'b0;
  logic [CHAR_IDX_W-1:0]  char_pos = '0;
  logic [VALUE_W-1:0]     range_acc = '0;
  logic [VALUE_W-1:0]     remis_acc = '0;
  logic [COUNT_W-1:0]     values_seen = '0;

  scan_result_t           results_due[$];
  logic [VALUE_W-1:0]     plan_range[$];
  logic [VALUE_W-1:0]     plan_remis[$];
  logic [BYTE_W-1:0]      frame_chars[$];

  int  mismatches = 0;
  int  bytes_sent = 0;
  int  cycles = 0;
  int  rx_hold_cycles = 0;
  int  rx_stall_left = 0;
  bit  tx_gap_on = 1'b1;
  bit  rx_stall_on = 1'b1;

  laser_range_data_decoder dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  function automatic logic [CLASS_W-1:0] class_of(input logic [VALUE_W-1:0] r);
    if (r >= min_rng) return CLASS_VALID;
    case (model_sel)
      MODEL_SHORT: begin
        return (r == '0) ? CLASS_TOO_FAR : CLASS_MEAS_ERR;
      end
      MODEL_LONG: begin
        if (r == LONG_TOO_FAR) return CLASS_TOO_FAR;
        if (r > LONG_TOO_FAR) return CLASS_OTHER_ERR;
      end
      default: begin
      end
    endcase
    return CLASS_VALID;
  endfunction

  function automatic void clear_value();
    char_pos = '0;
    range_acc = '0;
    remis_acc = '0;
  endfunction

  function automatic void take_char(input logic [BYTE_W-1:0] ch);
    logic [SIX_W-1:0] six;
    int unsigned      total;
    scan_result_t     r;
    six = SIX_W'(ch - DIGIT_BASE);
    total = rem_on ? 2 * CHARS_PER_VALUE : CHARS_PER_VALUE;
    if (char_pos < CHARS_PER_VALUE) begin
      range_acc = {range_acc[VALUE_W-SIX_W-1:0], six};
    end else begin
      remis_acc = {remis_acc[VALUE_W-SIX_W-1:0], six};
    end
    char_pos = char_pos + 1'b1;
    if (char_pos >= total) begin
      r.kind    = KIND_VALUE;
      r.range_v = range_acc;
      r.rem_v   = rem_on ? remis_acc : '0;
      r.cls     = class_of(range_acc);
      r.status  = STATUS_OK;
      r.last    = 1'b0;
      results_due.push_back(r);
      if (values_seen < MAX_COUNT_C) values_seen = values_seen + 1'b1;
      clear_value();
    end
  endfunction

  // A held byte is resolved only when the byte after it is known.
  function automatic void decode_rx_byte(input logic [BYTE_W-1:0] b);
    scan_result_t r;
    if (held_ok && b == LF_CHAR && held_char == LF_CHAR) begin
      r = '0;
      r.kind = KIND_END;
      r.last = 1'b1;
      if (char_pos != '0) r.status = STATUS_PARTIAL;
      else if (values_seen < count_goal) r.status = STATUS_TOO_FEW;
      else if (values_seen > count_goal) r.status = STATUS_TOO_MANY;
      else r.status = STATUS_OK;
      results_due.push_back(r);
      clear_value();
      values_seen = '0;
      held_ok = 1'b0;
      held_char = '0;
      return;
    end
    if (held_ok && b != LF_CHAR && held_char != LF_CHAR) take_char(held_char);
    held_char = b;
    held_ok = 1'b1;
  endfunction

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = VALUE_W'($urandom_range(0, 8));
      1: v = min_rng;
      2: v = min_rng - 1'b1;
      3: v = VALUE_MAX;
      4: v = VALUE_W'($urandom_range(0, 63));
      default: v = VALUE_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic void plan_value(input logic [VALUE_W-1:0] r, input logic [VALUE_W-1:0] m);
    plan_range.push_back(r);
    plan_remis.push_back(m);
  endfunction

  function automatic void plan_random(input int n);
    for (int i = 0; i < n; i++) plan_value(pick_value(), pick_value());
  endfunction

  function automatic void push_digits(input logic [VALUE_W-1:0] v);
    for (int k = CHARS_PER_VALUE - 1; k >= 0; k--) begin
      frame_chars.push_back(DIGIT_BASE + BYTE_W'(v[SIX_W*k +: SIX_W]));
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %0h got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = tx_gap_on ? idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_valid <= 1'b1;
    s_data <= b;
    do @(posedge clk); while (!s_ready);
    decode_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_REMISSION_EN: rem_on = data[0];
      REG_DEVICE_MODEL: model_sel = data[MODEL_W-1:0];
      REG_MIN_RANGE:    min_rng = data[VALUE_W-1:0];
      REG_EXPECTED_CNT: count_goal = data[EXPECT_W-1:0];
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input bit rem, input logic [MODEL_W-1:0] model,
                            input logic [VALUE_W-1:0] minr, input logic [EXPECT_W-1:0] goal);
    cfg_write(REG_REMISSION_EN, CFG_DATA_W'(rem));
    cfg_write(REG_DEVICE_MODEL, CFG_DATA_W'(model));
    cfg_write(REG_MIN_RANGE, CFG_DATA_W'(minr));
    cfg_write(REG_EXPECTED_CNT, CFG_DATA_W'(goal));
  endtask

  // Sends the planned values as lines of at most line_len value characters, each closed by
  // a checksum character and a line feed, and ends the block with a second line feed.
  task automatic send_frame(input int line_len, input bit noisy, input bit cut_short);
    logic [VALUE_W-1:0] v;
    logic [BYTE_W-1:0]  sum;
    int                 col;
    bit                 empty;
    while (plan_range.size() != 0) begin
      push_digits(plan_range.pop_front());
      v = plan_remis.pop_front();
      if (rem_on) push_digits(v);
    end
    if (cut_short && frame_chars.size() != 0) void'(frame_chars.pop_back());
    empty = (frame_chars.size() == 0);
    col = 0;
    while (frame_chars.size() != 0) begin
      if (noisy && $urandom_range(0, 15) == 0) send_byte(BYTE_W'($urandom));
      send_byte(frame_chars.pop_front());
      col++;
      if (col == line_len || frame_chars.size() == 0) begin
        sum = BYTE_W'($urandom);
        if (sum == LF_CHAR) sum = 8'h0B;
        send_byte(sum);
        send_byte(LF_CHAR);
        col = 0;
      end
    end
    if (empty) send_byte(LF_CHAR);
    send_byte(LF_CHAR);
  endtask

  task automatic test_reset_defaults();
    plan_value(0, 0);
    plan_value(5, 0);
    plan_value(19, 0);
    plan_value(20, 0);
    plan_value(VALUE_MAX, 0);
    send_frame(64, 1'b0, 1'b0);
    send_frame(64, 1'b0, 1'b0);
  endtask

  task automatic test_classing();
    for (int m = 0; m < 4; m++) begin
      set_config(1'b0, MODEL_W'(m), 100, 7);
      plan_value(0, 0);
      plan_value(3, 0);
      plan_value(LONG_TOO_FAR, 0);
      plan_value(5, 0);
      plan_value(99, 0);
      plan_value(100, 0);
      plan_value(VALUE_MAX, 0);
      send_frame(2, 1'b0, 1'b0);
    end
    set_config(1'b0, MODEL_LONG, '0, 3);
    plan_value(0, 0);
    plan_value(LONG_TOO_FAR, 0);
    plan_value(5, 0);
    send_frame(64, 1'b0, 1'b0);
    cfg_write(REG_MIN_RANGE, CFG_DATA_W'(VALUE_MAX));
    cfg_write(REG_DEVICE_MODEL, CFG_DATA_W'(MODEL_SHORT));
    plan_value(VALUE_MAX, 0);
    plan_value(VALUE_MAX - 1'b1, 0);
    plan_value(0, 0);
    send_frame(64, 1'b0, 1'b0);
  endtask

  task automatic test_remission();
    set_config(1'b1, MODEL_SHORT, MIN_RANGE_RESET, 3);
    plan_value(0, VALUE_MAX);
    plan_value(VALUE_MAX, 0);
    plan_value(pick_value(), pick_value());
    send_frame(5, 1'b0, 1'b0);
  endtask

  task automatic test_block_status();
    set_config(1'b0, MODEL_SHORT, MIN_RANGE_RESET, '1);
    plan_random(2);
    send_frame(64, 1'b0, 1'b0);
    cfg_write(REG_EXPECTED_CNT, 2);
    plan_random(2);
    send_frame(1, 1'b0, 1'b0);
    cfg_write(REG_EXPECTED_CNT, 1);
    plan_random(2);
    send_frame(64, 1'b0, 1'b0);
    cfg_write(REG_EXPECTED_CNT, 2);
    plan_random(2);
    send_frame(64, 1'b0, 1'b1);
    cfg_write(REG_EXPECTED_CNT, 0);
    send_frame(64, 1'b0, 1'b0);
  endtask

  task automatic test_odd_bytes();
    set_config(1'b0, MODEL_SHORT, MIN_RANGE_RESET, 3);
    send_byte(LF_CHAR);
    send_byte(8'h00);
    send_byte(8'h2F);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h0B);
    send_byte(8'h41);
    send_byte(LF_CHAR);
    send_byte(8'h30);
    send_byte(8'h31);
    send_byte(8'h6F);
    send_byte(8'h42);
    send_byte(LF_CHAR);
    send_byte(LF_CHAR);
  endtask

  task automatic test_remission_switch();
    set_config(1'b1, MODEL_LONG, 50, 2);
    send_byte(8'h31);
    send_byte(8'h32);
    send_byte(8'h33);
    send_byte(8'h34);
    cfg_write(REG_REMISSION_EN, 0);
    send_byte(8'h35);
    send_byte(8'h36);
    send_byte(8'h37);
    send_byte(8'h43);
    send_byte(LF_CHAR);
    send_byte(LF_CHAR);
    send_byte(8'h31);
    send_byte(8'h32);
    cfg_write(REG_REMISSION_EN, 1);
    send_byte(8'h33);
    send_byte(8'h34);
    send_byte(8'h35);
    send_byte(8'h36);
    send_byte(8'h37);
    send_byte(8'h44);
    send_byte(LF_CHAR);
    send_byte(LF_CHAR);
  endtask

  task automatic test_backpressure();
    set_config(1'b1, MODEL_LONG, 300, 40);
    tx_gap_on = 1'b0;
    rx_hold_cycles = 400;
    plan_random(40);
    send_frame(64, 1'b0, 1'b0);
    wait_idle();
    cfg_write(REG_EXPECTED_CNT, 10);
    plan_random(10);
    send_frame(7, 1'b0, 1'b0);
    tx_gap_on = 1'b1;
  endtask

  task automatic random_config();
    logic [VALUE_W-1:0] mr;
    case ($urandom_range(0, 4))
      0: mr = '0;
      1: mr = VALUE_MAX;
      2: mr = MIN_RANGE_RESET;
      3: mr = VALUE_W'($urandom_range(0, 300));
      default: mr = VALUE_W'($urandom);
    endcase
    cfg_write(REG_REMISSION_EN, CFG_DATA_W'($urandom));
    cfg_write(REG_DEVICE_MODEL, CFG_DATA_W'($urandom));
    cfg_write(REG_MIN_RANGE, mr);
  endtask

  task automatic test_random_stream();
    int start;
    int n;
    int roll;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) random_config();
      if (roll % 4 == 0) begin
        tx_gap_on = 1'($urandom_range(0, 1));
        rx_stall_on = 1'($urandom_range(0, 1));
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
      plan_random(n);
      if ($urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 4) == 0) cfg_write(REG_EXPECTED_CNT, CFG_DATA_W'($urandom));
        else cfg_write(REG_EXPECTED_CNT, CFG_DATA_W'(n + $urandom_range(0, 2) - 1));
      end
      if (roll >= 90) begin
        repeat ($urandom_range(1, 8)) begin
          send_byte(($urandom_range(0, 2) == 0) ? LF_CHAR : BYTE_W'($urandom));
        end
      end
      send_frame($urandom_range(1, 64), $urandom_range(0, 6) == 0, $urandom_range(0, 9) == 0);
    end
    tx_gap_on = 1'b1;
    rx_stall_on = 1'b1;
  endtask

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        m_ready <= 1'b0;
        rx_hold_cycles--;
      end else if (rx_stall_left > 0) begin
        m_ready <= 1'b0;
        rx_stall_left--;
      end else begin
        m_ready <= 1'b1;
        if (rx_stall_on && $urandom_range(0, 2) == 0) rx_stall_left = idle_len();
      end
    end
  end

  always @(posedge clk) begin : check_outputs
    scan_result_t want;
    if (rst_n && m_valid && m_ready) begin
      if (results_due.size() == 0) begin
        $error("output transfer with no result due");
        mismatches++;
      end else begin
        want = results_due.pop_front();
        check_field("item_kind", 32'(want.kind), 32'(m_user));
        check_field("range_mm", 32'(want.range_v), 32'(m_data[VALUE_W-1:0]));
        check_field("remission_level", 32'(want.rem_v), 32'(m_data[VALUE_W +: VALUE_W]));
        check_field("range_class", 32'(want.cls), 32'(m_data[2*VALUE_W +: CLASS_W]));
        check_field("block_status", 32'(want.status),
                    32'(m_data[2*VALUE_W+CLASS_W +: STATUS_W]));
        check_field("is_last", 32'(want.last), 32'(m_last));
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL laser_range_data_decoder");
        $finish;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_classing();
    test_remission();
    test_block_status();
    test_odd_bytes();
    test_remission_switch();
    test_backpressure();
    test_random_stream();
    wait_idle();
    repeat (DRAIN_CYCLES * 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS laser_range_data_decoder");
    end else begin
      $display("FAIL laser_range_data_decoder");
    end
    $finish;
  end

endmodule
